### hdl/magic_sequence_baud_scan_detector_defines.svh
// Assertion macros used by the detector core.
// Each macro takes a label, the clock and the active-low reset.
`ifndef MAGIC_SEQUENCE_BAUD_SCAN_DETECTOR_DEFINES_SVH
`define MAGIC_SEQUENCE_BAUD_SCAN_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Condition holds at every edge outside reset
`define MSBD_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// Antecedent implies consequent in the same cycle
`define MSBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define MSBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define MSBD_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define MSBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MSBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/msbd_pkg.sv
package msbd_pkg;

	localparam int MAGIC_W = 32;
	localparam int LEN_W   = 16;
	localparam int DIV_W   = 16;
	localparam int IDX_W   = 3;

	// Input item kinds
	typedef enum logic [1:0] {
		OP_START,
		OP_TICK,
		OP_BYTE
	} op_t;

	// Result event codes
	typedef enum logic [1:0] {
		EV_NONE,
		EV_NEXT_SLOT,
		EV_MATCHED,
		EV_TIMEOUT
	} event_t;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_MAGIC_LOW,
		REG_MAGIC_HIGH,
		REG_WINDOW_MS,
		REG_DIV_SLOT0,
		REG_DIV_SLOT1,
		REG_DIV_SLOT2
	} reg_idx_t;

	// Register reset values
	localparam logic [MAGIC_W-1:0] RST_MAGIC_LOW  = 32'h5AA5_5AA5;
	localparam logic [MAGIC_W-1:0] RST_MAGIC_HIGH = 32'hA55A_A55A;
	localparam logic [LEN_W-1:0]   RST_WINDOW_MS  = 16'd500;
	localparam logic [DIV_W-1:0]   RST_DIV_SLOT0  = 16'd17;
	localparam logic [DIV_W-1:0]   RST_DIV_SLOT1  = 16'd139;
	localparam logic [DIV_W-1:0]   RST_DIV_SLOT2  = 16'd1667;

	// Decoded configuration handed to the datapath
	typedef struct packed {
		logic [MAGIC_W-1:0] magic_low;
		logic [MAGIC_W-1:0] magic_high;
		logic [LEN_W-1:0]   base_len;  // length of every slot but the last
		logic [LEN_W-1:0]   last_len;  // length of the last slot
		logic [DIV_W-1:0]   div0;
		logic [DIV_W-1:0]   div1;
		logic [DIV_W-1:0]   div2;
	} cfg_t;

	// One result item
	typedef struct packed {
		event_t           event_res;
		logic [DIV_W-1:0] baud_divisor;
		logic [1:0]       slot_index;
		logic             listening;
	} res_t;

	// Byte k of the 64-bit magic sequence, byte 0 lowest
	function automatic logic [7:0] magic_byte(input logic [2*MAGIC_W-1:0] magic,
	                                           input logic [2:0] k);
		return magic[{k, 3'b000} +: 8];
	endfunction

endpackage

### hdl/magic_sequence_baud_scan_detector.sv
// Serial magic-sequence detector with a three-slot baud scan. A start item
// (tuser 0) opens a window of window_ms ticks; the first slots last
// window_ms/SLOT_COUNT ticks each and the last slot takes the rest. Tick
// items (tuser 1) advance the slot timer, byte items (tuser 2) are matched
// against the 8-byte magic sequence from magic_low/magic_high. Every input
// transaction yields exactly one result: event, divisor of the current
// slot (0 when idle), slot index and listening flag. One item is taken per
// clock while the result register can drain; the input register loads at
// the accepting edge and the state update fills the result register when
// the pipeline advances. A stalled result register holds the input
// register, which then holds off new input.
// Configuration writes are taken every cycle and must only be issued while
// no items are in flight.
module magic_sequence_baud_scan_detector
	import msbd_pkg::*;
#(
	parameter int MAGIC_LENGTH = 8,
	parameter int SLOT_COUNT   = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	// input stream
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // [7:0] rx_byte
	input  logic [1:0]         s_axis_tuser,  // [1:0] op
	// result stream
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [23:0]        m_axis_tdata,  // [15:0] baud_divisor, [17:16] slot_index,
	                                          // [18] listening, [23:19] zero
	output logic [1:0]         m_axis_tuser,  // [1:0] event_res
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [MAGIC_W-1:0] cfg_data
);

	logic       v_s1;
	op_t        op_s1;
	logic [7:0] rx_s1;
	logic       out_valid_q;
	res_t       out_q;
	res_t       res;
	cfg_t       cfg;
	logic       adv, fire;

	assign cfg_ready = 1'b1;

	msbd_cfg #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	msbd_core #(
		.MAGIC_LENGTH (MAGIC_LENGTH),
		.SLOT_COUNT   (SLOT_COUNT)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.fire    (fire),
		.op      (op_s1),
		.rx_byte (rx_s1),
		.res     (res)
	);

	// Pipeline moves when the result register is free or being drained
	assign adv           = !out_valid_q || m_axis_tready;
	assign fire          = v_s1 && adv;
	assign s_axis_tready = !v_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1 <= op_t'(s_axis_tuser);
			rx_s1 <= s_axis_tdata;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.event_res;
	assign m_axis_tdata  = {5'b0, out_q.listening, out_q.slot_index, out_q.baud_divisor};

endmodule

### hdl/msbd_cfg.sv
module msbd_cfg
	import msbd_pkg::*;
#(
	parameter int SLOT_COUNT = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_index,
	input  logic [MAGIC_W-1:0]  wr_data,
	output cfg_t                cfg
);

	// Reciprocal of the slot count, 17 fractional bits (exact for 16-bit values)
	localparam logic [17:0] RECIP = 18'((2**17 + SLOT_COUNT - 1) / SLOT_COUNT);
	localparam logic [LEN_W-1:0] RST_BASE = LEN_W'(RST_WINDOW_MS / SLOT_COUNT);

	logic [MAGIC_W-1:0] magic_low_q, magic_high_q;
	logic [LEN_W-1:0]   window_q, base_q;
	logic [DIV_W-1:0]   div0_q, div1_q, div2_q;
	logic [33:0]        quot_prod;
	logic [LEN_W-1:0]   wr_base;

	// window / SLOT_COUNT by reciprocal multiply, taken at write time
	assign quot_prod = 34'(wr_data[LEN_W-1:0]) * 34'(RECIP);
	assign wr_base   = quot_prod[32:17];

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_low_q  <= RST_MAGIC_LOW;
			magic_high_q <= RST_MAGIC_HIGH;
			window_q     <= RST_WINDOW_MS;
			base_q       <= RST_BASE;
			div0_q       <= RST_DIV_SLOT0;
			div1_q       <= RST_DIV_SLOT1;
			div2_q       <= RST_DIV_SLOT2;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MAGIC_LOW:  magic_low_q  <= wr_data;
				REG_MAGIC_HIGH: magic_high_q <= wr_data;
				REG_WINDOW_MS: begin
					window_q <= wr_data[LEN_W-1:0];
					base_q   <= wr_base;
				end
				REG_DIV_SLOT0:  div0_q <= wr_data[DIV_W-1:0];
				REG_DIV_SLOT1:  div1_q <= wr_data[DIV_W-1:0];
				REG_DIV_SLOT2:  div2_q <= wr_data[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// Last slot takes the remainder of the window
	always_comb begin
		cfg.magic_low  = magic_low_q;
		cfg.magic_high = magic_high_q;
		cfg.base_len   = base_q;
		cfg.last_len   = window_q - base_q * LEN_W'(SLOT_COUNT - 1);
		cfg.div0       = div0_q;
		cfg.div1       = div1_q;
		cfg.div2       = div2_q;
	end

endmodule

### hdl/msbd_core.sv
`include "magic_sequence_baud_scan_detector_defines.svh"

module msbd_core
	import msbd_pkg::*;
#(
	parameter int MAGIC_LENGTH = 8,
	parameter int SLOT_COUNT   = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       fire,      // item in stage 1 moves to the result register
	input  op_t        op,
	input  logic [7:0] rx_byte,
	output res_t       res
);

	localparam int MC_W = $clog2(MAGIC_LENGTH + 1);

	logic            active_q, active_nxt;
	logic [1:0]      slot_q, slot_nxt;
	logic [LEN_W-1:0] elapsed_q, elapsed_nxt, elapsed_inc, len;
	logic [MC_W-1:0] count_q, count_nxt, count_inc;
	logic            last_slot;
	logic [7:0]      exp_byte, first_byte;
	event_t          ev;
	logic [DIV_W-1:0] div_sel;

	// Current slot length and magic byte lookups
	assign last_slot   = (3'({1'b0, slot_q}) + 3'd1) >= 3'(SLOT_COUNT);
	assign len         = last_slot ? cfg.last_len : cfg.base_len;
	assign elapsed_inc = (elapsed_q != {LEN_W{1'b1}}) ? elapsed_q + 1'b1 : elapsed_q;
	assign count_inc   = count_q + 1'b1;
	assign exp_byte    = magic_byte({cfg.magic_high, cfg.magic_low}, 3'(count_q));
	assign first_byte  = cfg.magic_low[7:0];

	// Next state and event for the item at hand
	always_comb begin
		active_nxt  = active_q;
		slot_nxt    = slot_q;
		elapsed_nxt = elapsed_q;
		count_nxt   = count_q;
		ev          = EV_NONE;
		case (op)
			OP_START: begin
				active_nxt  = 1'b1;
				slot_nxt    = '0;
				elapsed_nxt = '0;
				count_nxt   = '0;
			end
			OP_TICK: begin
				if (active_q) begin
					elapsed_nxt = elapsed_inc;
					if (elapsed_inc >= len) begin
						if (last_slot) begin
							active_nxt = 1'b0;
							ev         = EV_TIMEOUT;
						end else begin
							slot_nxt    = slot_q + 1'b1;
							elapsed_nxt = '0;
							count_nxt   = '0;
							ev          = EV_NEXT_SLOT;
						end
					end
				end
			end
			OP_BYTE: begin
				// a zero-length slot takes no byte
				if (active_q && (elapsed_q < len)) begin
					if (rx_byte == exp_byte) begin
						count_nxt = count_inc;
						if (count_inc >= MC_W'(MAGIC_LENGTH)) begin
							active_nxt = 1'b0;
							ev         = EV_MATCHED;
						end
					end else begin
						count_nxt = (rx_byte == first_byte) ? MC_W'(1) : '0;
					end
				end
			end
			default: ;
		endcase
	end

	// Divisor of the slot after the update
	always_comb begin
		case (slot_nxt)
			2'd0:    div_sel = cfg.div0;
			2'd1:    div_sel = cfg.div1;
			default: div_sel = cfg.div2;
		endcase
		res.event_res    = ev;
		res.baud_divisor = active_nxt ? div_sel : '0;
		res.slot_index   = slot_nxt;
		res.listening    = active_nxt;
	end

	// Detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			slot_q    <= '0;
			elapsed_q <= '0;
			count_q   <= '0;
		end else if (fire) begin
			active_q  <= active_nxt;
			slot_q    <= slot_nxt;
			elapsed_q <= elapsed_nxt;
			count_q   <= count_nxt;
		end
	end

	`MSBD_ASSERT_ALWAYS(a_slot_range, clk, arst_n, 3'({1'b0, slot_q}) < 3'(SLOT_COUNT))
	`MSBD_ASSERT_SAME(a_count_below_len, clk, arst_n, active_q, count_q < MC_W'(MAGIC_LENGTH))
	`MSBD_ASSERT_NEXT(a_start_clears, clk, arst_n, fire && (op == OP_START), active_q && (slot_q == 2'd0) && (elapsed_q == '0) && (count_q == '0))
	`MSBD_ASSERT_NEXT(a_idle_byte_holds, clk, arst_n, fire && (op == OP_BYTE) && !active_q, $stable(count_q) && !active_q)

endmodule

### tb/sv/testbench.sv
module testbench;
	import msbd_pkg::*;

	// op value with no meaning; the detector must ignore it
	localparam logic [1:0] OP_UNUSED = 2'b11;
	localparam int SLOTS = 3;
	localparam int SEQ_LEN = 8;
	localparam int RAND_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 85;
	localparam int PAUSE_POINT = 40;

	// Mirror of the detector state; predicts one result per input transaction
	class scan_mirror_t;
		logic [31:0] magic_lo;
		logic [31:0] magic_hi;
		logic [15:0] window;
		logic [15:0] div [SLOTS];
		bit          on;
		logic [1:0]  slot;
		logic [15:0] elapsed;
		logic [3:0]  count;
		res_t        awaited[$];
		int          errors;
		int          results;
		int          match_hits;
		int          timeouts;
		int          slot_moves;

		function new();
			magic_lo = RST_MAGIC_LOW;
			magic_hi = RST_MAGIC_HIGH;
			window = RST_WINDOW_MS;
			div[0] = RST_DIV_SLOT0;
			div[1] = RST_DIV_SLOT1;
			div[2] = RST_DIV_SLOT2;
			on = 1'b0;
			slot = '0;
			elapsed = '0;
			count = '0;
			errors = 0;
			results = 0;
			match_hits = 0;
			timeouts = 0;
			slot_moves = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_MAGIC_LOW:  magic_lo = val;
				REG_MAGIC_HIGH: magic_hi = val;
				REG_WINDOW_MS:  window = val[15:0];
				REG_DIV_SLOT0:  div[0] = val[15:0];
				REG_DIV_SLOT1:  div[1] = val[15:0];
				REG_DIV_SLOT2:  div[2] = val[15:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] byte_at(logic [2:0] k);
			logic [63:0] seq;
			seq = {magic_hi, magic_lo} >> (8 * k);
			return seq[7:0];
		endfunction

		// first slots get window/3 ticks, the last one the remainder
		function logic [15:0] slot_len(logic [1:0] s);
			logic [15:0] base;
			base = window / 16'd3;
			if (s < SLOTS - 1)
				return base;
			return window - 16'(2 * base);
		endfunction

		function void absorb_item(logic [1:0] op, logic [7:0] rx);
			event_t ev;
			res_t   want;
			ev = EV_NONE;
			if (op == OP_START) begin
				on = 1'b1;
				slot = '0;
				elapsed = '0;
				count = '0;
			end else if (op == OP_TICK && on) begin
				if (elapsed != 16'hFFFF)
					elapsed++;
				if (elapsed >= slot_len(slot)) begin
					if (slot == SLOTS - 1) begin
						on = 1'b0;
						ev = EV_TIMEOUT;
					end else begin
						slot++;
						elapsed = '0;
						count = '0;
						ev = EV_NEXT_SLOT;
					end
				end
			end else if (op == OP_BYTE && on) begin
				// a zero-length slot takes no byte
				if (elapsed < slot_len(slot)) begin
					if (rx == byte_at(count[2:0])) begin
						count++;
						if (count >= SEQ_LEN) begin
							on = 1'b0;
							ev = EV_MATCHED;
						end
					end else begin
						count = (rx == byte_at(3'd0)) ? 4'd1 : 4'd0;
					end
				end
			end
			want.event_res = ev;
			want.baud_divisor = on ? div[slot] : '0;
			want.slot_index = slot;
			want.listening = on;
			awaited.push_back(want);
		endfunction

		function void field_check(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void compare_result(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result with nothing awaited: event %0d divisor %0d slot %0d listening %0d",
					$time, got.event_res, got.baud_divisor, got.slot_index, got.listening);
				errors++;
				return;
			end
			want = awaited.pop_front();
			results++;
			case (want.event_res)
				EV_NEXT_SLOT: slot_moves++;
				EV_MATCHED:   match_hits++;
				EV_TIMEOUT:   timeouts++;
				default: ;
			endcase
			field_check("event_res", want.event_res, got.event_res);
			field_check("baud_divisor", want.baud_divisor, got.baud_divisor);
			field_check("slot_index", want.slot_index, got.slot_index);
			field_check("listening", want.listening, got.listening);
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = '0;   // [7:0] rx_byte
	logic [1:0]         s_axis_tuser = '0;   // [1:0] op
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [23:0]        m_axis_tdata;        // [15:0] baud_divisor, [17:16] slot_index,
	                                         // [18] listening, [23:19] zero
	logic [1:0]         m_axis_tuser;        // [1:0] event_res
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [MAGIC_W-1:0] cfg_data = '0;

	scan_mirror_t sb = new();
	bit send_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	int stall_left = 0;
	int items_sent = 0;

	magic_sequence_baud_scan_detector u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		return ($urandom_range(0, 3) != 0) ? $urandom_range(1, 3) : $urandom_range(8, 30);
	endfunction

	// Result side back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if (rx_stalls && $urandom_range(0, 99) < 30) begin
			m_axis_tready <= 1'b0;
			stall_left = gap_len() - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Result monitor
	always @(posedge clk) begin : result_mon
		res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.event_res = event_t'(m_axis_tuser);
			got.baud_divisor = m_axis_tdata[15:0];
			got.slot_index = m_axis_tdata[17:16];
			got.listening = m_axis_tdata[18];
			sb.compare_result(got);
		end
	end

	task automatic send_item(logic [1:0] op, logic [7:0] rx);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= rx;
		do @(posedge clk); while (!s_axis_tready);
		sb.absorb_item(op, rx);
		items_sent++;
	endtask

	task automatic sender_gap();
		int n;
		if (!send_gaps || $urandom_range(0, 99) >= 40)
			return;
		n = gap_len();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// hold off input until every awaited result is back, then let the pipe settle
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_divisor(int p);
		logic [31:0] v;
		v = $urandom;
		if (p == 0)
			v[15:0] = 16'd1;
		else if (p == 4)
			v[15:0] = 16'hFFFF;
		else
			v[15:0] = $urandom_range(1, 65535);
		return v;
	endfunction

	// Per-phase settings; the early phases hit the extremes
	task automatic configure_phase(int p);
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] win;
		logic [7:0]  b;
		lo = $urandom;
		hi = $urandom;
		b = $urandom_range(0, 255);
		case (p)
			1: begin
				lo = '0;
				hi = '0;
			end
			2: begin
				lo = '1;
				hi = '1;
			end
			3: begin
				lo = {4{b}};
				hi = {4{b}};
			end
			default: ;
		endcase
		win = $urandom;
		case (p)
			0: win[15:0] = 16'd0;
			1: win[15:0] = 16'd1;
			2: win[15:0] = 16'd2;
			3: win[15:0] = 16'd3;
			4: win[15:0] = 16'hFFFF;
			default: win[15:0] = $urandom_range(6, 40);
		endcase
		write_reg(REG_MAGIC_LOW, lo);
		write_reg(REG_MAGIC_HIGH, hi);
		write_reg(REG_WINDOW_MS, win);
		write_reg(REG_DIV_SLOT0, pick_divisor(p));
		write_reg(REG_DIV_SLOT1, pick_divisor(p));
		write_reg(REG_DIV_SLOT2, pick_divisor(p));
	endtask

	// Stimulus
	initial begin
		logic [1:0] op;
		logic [7:0] rx;
		int         r;
		int         counted;
		bit         counts;
		bit         mid_pause;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// idle detector, unused op, then a match with both restart flavors
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_UNUSED, 8'h5A);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, sb.byte_at(3'd0));
		send_item(OP_BYTE, sb.byte_at(3'd1));
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, sb.byte_at(3'd0));
		send_item(OP_BYTE, sb.byte_at(3'd0));
		for (int k = 1; k < SEQ_LEN; k++)
			send_item(OP_BYTE, sb.byte_at(3'(k)));
		// restart while listening
		send_item(OP_START, 8'hFF);
		send_item(OP_START, 8'h00);
		wait_idle();

		// zero-length first slots, byte in the last slot, then timeout
		write_reg(REG_WINDOW_MS, 32'd2);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, sb.byte_at(3'd0));
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, sb.byte_at(3'd0));
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'h00);

		// Random phases: mostly well-formed sequences, some noise
		for (int p = 0; p < RAND_PHASES; p++) begin
			wait_idle();
			configure_phase(p);
			send_gaps = $urandom_range(0, 3) != 0;
			rx_stalls = $urandom_range(0, 3) != 0;
			mid_pause = (p == 0) || ($urandom_range(0, 1) != 0);
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				if (!sb.on && $urandom_range(0, 3) != 0) begin
					op = OP_START;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 3)
						op = OP_START;
					else if (r < 6)
						op = OP_UNUSED;
					else if (r < 38)
						op = OP_TICK;
					else
						op = OP_BYTE;
				end
				r = $urandom_range(0, 99);
				if (op == OP_BYTE && r < 70)
					rx = sb.byte_at(sb.count[2:0]);
				else if (op == OP_BYTE && r < 85)
					rx = sb.byte_at(3'd0);
				else
					rx = $urandom_range(0, 255);
				counts = (op == OP_START) || (sb.on && (op == OP_TICK || op == OP_BYTE));
				send_item(op, rx);
				if (counts)
					counted++;
				if (mid_pause && counted >= PAUSE_POINT) begin
					mid_pause = 1'b0;
					wait_idle();
				end
				sender_gap();
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("run covered %0d input transactions over %0d settings, %0d results checked",
			items_sent, RAND_PHASES + 2, sb.results);
		$display("events seen: %0d slot moves, %0d matches, %0d timeouts",
			sb.slot_moves, sb.match_hits, sb.timeouts);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("%0t: run did not complete, %0d results still awaited", $time,
			sb.awaited.size());
		$display("status: fail");
		$finish;
	end

endmodule

### magic_sequence_baud_scan_detector.f
+incdir+hdl
hdl/msbd_pkg.sv
hdl/msbd_cfg.sv
hdl/msbd_core.sv
hdl/magic_sequence_baud_scan_detector.sv
tb/sv/testbench.sv
